@@ sv/blaq_pkg.sv @@
// ----------------------------------------------------------------------------
// blaq_pkg
// Shared constants, types and the ramp table of the luma ASCII quantizer.
// ----------------------------------------------------------------------------
package blaq_pkg;

	localparam int MAX_IMAGE_WIDTH = 1024;
	localparam int MAX_BLOCK_SIDE  = 64;
	localparam int HEIGHT_LIMIT    = 1024;

	localparam int COL_W = $clog2(MAX_IMAGE_WIDTH);
	localparam int ROW_W = $clog2(HEIGHT_LIMIT);
	localparam int OFS_W = (MAX_BLOCK_SIDE > 1) ? $clog2(MAX_BLOCK_SIDE) : 1;

	// register and port widths
	localparam int IMG_REG_W  = 11;
	localparam int BLK_REG_W  = 7;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int PIX_W      = 8;
	localparam int LEVEL_W    = 4;
	localparam int CHAR_W     = 7;
	localparam int ZONE_W     = 10;

	localparam int IMG_W_RESET = 640;
	localparam int IMG_H_RESET = 480;
	localparam int BLK_W_RESET = 8;
	localparam int BLK_H_RESET = 16;

	// BT.601 weights, 16 fraction bits, summing to one
	localparam int LUMA_FRAC = 16;
	localparam int W_RED     = 19595;
	localparam int W_GREEN   = 38470;
	localparam int W_BLUE    = 7471;
	localparam int PIX_MAX   = 255;
	localparam int LUMA_W    = PIX_W + LUMA_FRAC;

	localparam int CNT_W  = $clog2(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE) + 1;
	localparam int SUM_W  = LUMA_W + CNT_W - 1;
	localparam int ACC_W  = SUM_W + CNT_W;
	// 9*sum with the fraction bits dropped
	localparam int XH_W   = SUM_W + 4 - LUMA_FRAC;

	localparam int LEVEL_MAX = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_BLOCK_WIDTH,
		REG_BLOCK_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic [ZONE_W-1:0] col;
		logic [ZONE_W-1:0] row;
		logic              last;
	} zone_meta_t;

	typedef struct packed {
		zone_meta_t meta;
		logic       start;   // top-left pixel of a zone
		logic       finish;  // bottom-right pixel of a zone
	} pixel_pos_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} acc_entry_t;

	function automatic logic [CHAR_W-1:0] ramp_char(input logic [LEVEL_W-1:0] level);
		logic [CHAR_W-1:0] c;
		unique case (level)
			4'd0:    c = 7'd32;  // ' '
			4'd1:    c = 7'd46;  // '.'
			4'd2:    c = 7'd58;  // ':'
			4'd3:    c = 7'd45;  // '-'
			4'd4:    c = 7'd61;  // '='
			4'd5:    c = 7'd43;  // '+'
			4'd6:    c = 7'd42;  // '*'
			4'd7:    c = 7'd35;  // '#'
			4'd8:    c = 7'd37;  // '%'
			4'd9:    c = 7'd64;  // '@'
			default: c = 7'd32;
		endcase
		return c;
	endfunction

endpackage

@@ sv/blaq_ram.sv @@
// ----------------------------------------------------------------------------
// blaq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module blaq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 49
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/blaq_raster.sv @@
// ----------------------------------------------------------------------------
// blaq_raster
// Configuration registers and raster position tracking (pixel, offset in
// zone, zone indices). Flags zone start, zone finish and image end.
// ----------------------------------------------------------------------------
module blaq_raster (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr,
	input  logic [blaq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blaq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            step,
	output blaq_pkg::pixel_pos_t            pos
);

	localparam int CW = blaq_pkg::COL_W;
	localparam int RW = blaq_pkg::ROW_W;
	localparam int OW = blaq_pkg::OFS_W;

	logic [blaq_pkg::IMG_REG_W-1:0] img_w_q, img_h_q;
	logic [blaq_pkg::BLK_REG_W-1:0] blk_w_q, blk_h_q;

	logic [CW-1:0] col_q, zone_col_q;
	logic [RW-1:0] row_q, zone_row_q;
	logic [OW-1:0] ofs_x_q, ofs_y_q;

	logic [CW:0] w_eff, col_inc;
	logic [RW:0] h_eff, row_inc;
	logic [OW:0] bw_eff, bh_eff, ofs_x_inc, ofs_y_inc;
	logic        col_end, row_end, ofs_x_end, ofs_y_end;

	// zero reads as one, oversize reads as the limit
	always_comb begin
		if (img_w_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (img_w_q > blaq_pkg::IMG_REG_W'(blaq_pkg::MAX_IMAGE_WIDTH)) begin
			w_eff = (CW+1)'(blaq_pkg::MAX_IMAGE_WIDTH);
		end else begin
			w_eff = (CW+1)'(img_w_q);
		end
		if (img_h_q == '0) begin
			h_eff = (RW+1)'(1);
		end else if (img_h_q > blaq_pkg::IMG_REG_W'(blaq_pkg::HEIGHT_LIMIT)) begin
			h_eff = (RW+1)'(blaq_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = (RW+1)'(img_h_q);
		end
		if (blk_w_q == '0) begin
			bw_eff = (OW+1)'(1);
		end else if (9'(blk_w_q) > 9'(blaq_pkg::MAX_BLOCK_SIDE)) begin
			bw_eff = (OW+1)'(blaq_pkg::MAX_BLOCK_SIDE);
		end else begin
			bw_eff = (OW+1)'(blk_w_q);
		end
		if (blk_h_q == '0) begin
			bh_eff = (OW+1)'(1);
		end else if (9'(blk_h_q) > 9'(blaq_pkg::MAX_BLOCK_SIDE)) begin
			bh_eff = (OW+1)'(blaq_pkg::MAX_BLOCK_SIDE);
		end else begin
			bh_eff = (OW+1)'(blk_h_q);
		end
	end

	assign col_inc   = {1'b0, col_q} + (CW+1)'(1);
	assign row_inc   = {1'b0, row_q} + (RW+1)'(1);
	assign ofs_x_inc = {1'b0, ofs_x_q} + (OW+1)'(1);
	assign ofs_y_inc = {1'b0, ofs_y_q} + (OW+1)'(1);

	assign col_end   = col_inc >= w_eff;
	assign row_end   = row_inc >= h_eff;
	assign ofs_x_end = ofs_x_inc >= bw_eff;
	assign ofs_y_end = ofs_y_inc >= bh_eff;

	assign pos.meta.col  = blaq_pkg::ZONE_W'(zone_col_q);
	assign pos.meta.row  = blaq_pkg::ZONE_W'(zone_row_q);
	assign pos.meta.last = col_end && row_end;
	assign pos.start     = (ofs_x_q == '0) && (ofs_y_q == '0);
	assign pos.finish    = (ofs_x_end || col_end) && (ofs_y_end || row_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q    <= blaq_pkg::IMG_REG_W'(blaq_pkg::IMG_W_RESET);
			img_h_q    <= blaq_pkg::IMG_REG_W'(blaq_pkg::IMG_H_RESET);
			blk_w_q    <= blaq_pkg::BLK_REG_W'(blaq_pkg::BLK_W_RESET);
			blk_h_q    <= blaq_pkg::BLK_REG_W'(blaq_pkg::BLK_H_RESET);
			col_q      <= '0;
			row_q      <= '0;
			ofs_x_q    <= '0;
			ofs_y_q    <= '0;
			zone_col_q <= '0;
			zone_row_q <= '0;
		end else if (cfg_wr) begin
			unique case (blaq_pkg::cfg_reg_t'(cfg_index))
				blaq_pkg::REG_IMAGE_WIDTH:  img_w_q <= blaq_pkg::IMG_REG_W'(cfg_data);
				blaq_pkg::REG_IMAGE_HEIGHT: img_h_q <= blaq_pkg::IMG_REG_W'(cfg_data);
				blaq_pkg::REG_BLOCK_WIDTH:  blk_w_q <= blaq_pkg::BLK_REG_W'(cfg_data);
				blaq_pkg::REG_BLOCK_HEIGHT: blk_h_q <= blaq_pkg::BLK_REG_W'(cfg_data);
			endcase
			// any write restarts the image
			col_q      <= '0;
			row_q      <= '0;
			ofs_x_q    <= '0;
			ofs_y_q    <= '0;
			zone_col_q <= '0;
			zone_row_q <= '0;
		end else if (step) begin
			if (col_end) begin
				col_q      <= '0;
				ofs_x_q    <= '0;
				zone_col_q <= '0;
				if (row_end) begin
					row_q      <= '0;
					ofs_y_q    <= '0;
					zone_row_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
					if (ofs_y_end) begin
						ofs_y_q    <= '0;
						zone_row_q <= zone_row_q + RW'(1);
					end else begin
						ofs_y_q <= ofs_y_q + OW'(1);
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
				if (ofs_x_end) begin
					ofs_x_q    <= '0;
					zone_col_q <= zone_col_q + CW'(1);
				end else begin
					ofs_x_q <= ofs_x_q + OW'(1);
				end
			end
		end
	end

endmodule

@@ sv/blaq_accum.sv @@
// ----------------------------------------------------------------------------
// blaq_accum
// Per zone column luma sum and pixel count, kept in RAM. Read on accept,
// modify and write back in the following cycle.
// ----------------------------------------------------------------------------
module blaq_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  blaq_pkg::pixel_pos_t        pos,
	input  logic [blaq_pkg::PIX_W-1:0]  red,
	input  logic [blaq_pkg::PIX_W-1:0]  green,
	input  logic [blaq_pkg::PIX_W-1:0]  blue,
	output logic                        busy,
	output logic                        push,
	output blaq_pkg::acc_entry_t        acc,
	output blaq_pkg::zone_meta_t        meta
);

	localparam int LW = blaq_pkg::LUMA_W;
	localparam int CW = blaq_pkg::COL_W;

	logic                 busy_s1, start_s1, finish_s1;
	logic [LW-1:0]        luma_d, luma_s1;
	logic [CW-1:0]        addr_s1;
	blaq_pkg::zone_meta_t meta_s1;

	logic [blaq_pkg::ACC_W-1:0] rd_data;
	blaq_pkg::acc_entry_t       base, upd;

	assign luma_d = LW'(LW'(blaq_pkg::W_RED) * LW'(red))
		+ LW'(LW'(blaq_pkg::W_GREEN) * LW'(green))
		+ LW'(LW'(blaq_pkg::W_BLUE) * LW'(blue));

	blaq_ram #(
		.DEPTH(blaq_pkg::MAX_IMAGE_WIDTH),
		.WIDTH(blaq_pkg::ACC_W)
	) u_ram (
		.clk  (clk),
		.we   (busy_s1),
		.waddr(addr_s1),
		.wdata(upd),
		.re   (take),
		.raddr(CW'(pos.meta.col)),
		.rdata(rd_data)
	);

	// zone start discards whatever the column held
	always_comb begin
		base    = start_s1 ? '0 : blaq_pkg::acc_entry_t'(rd_data);
		upd.sum = base.sum + blaq_pkg::SUM_W'(luma_s1);
		upd.cnt = base.cnt + blaq_pkg::CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			luma_s1   <= luma_d;
			addr_s1   <= CW'(pos.meta.col);
			meta_s1   <= pos.meta;
			start_s1  <= pos.start;
			finish_s1 <= pos.finish;
		end
	end

	assign busy = busy_s1;
	assign push = busy_s1 && finish_s1;
	assign acc  = upd;
	assign meta = meta_s1;

`ifndef SYNTHESIS
	a_rmw_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> !busy_s1)
		else $error("read-modify-write held longer than one cycle");
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !busy_s1)
		else $error("new read issued while write-back pending");
`endif

endmodule

@@ sv/blaq_quant.sv @@
// ----------------------------------------------------------------------------
// blaq_quant
// Quantizer tail: level = number of k in 1..9 with 9*sum >= k*255*2^16*count,
// in pipeline stages (operands with thresholds, then compare) and an output register.
// ----------------------------------------------------------------------------
module blaq_quant (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  blaq_pkg::acc_entry_t          acc,
	input  blaq_pkg::zone_meta_t          meta_in,
	output logic                          full,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [blaq_pkg::LEVEL_W-1:0]  ramp_level,
	output logic [blaq_pkg::CHAR_W-1:0]   char_code,
	output logic [blaq_pkg::ZONE_W-1:0]   zone_column,
	output logic [blaq_pkg::ZONE_W-1:0]   zone_row,
	output logic                          last_zone
);

	localparam int SW = blaq_pkg::SUM_W;
	localparam int XW = blaq_pkg::XH_W;
	localparam int LM = blaq_pkg::LEVEL_MAX;

	logic                    valid_s1, valid_s2, out_valid_q;
	logic                    adv1, adv2;
	logic [SW-1:0]           sum_s1;
	logic [blaq_pkg::CNT_W-1:0] cnt_s1;
	blaq_pkg::zone_meta_t    meta_s1, meta_s2, meta_q;

	logic [SW+3:0]           nine_sum;
	logic [XW-1:0]           xh_d, xh_s2;
	logic [XW-1:0]           thr_d  [1:LM];
	logic [XW-1:0]           thr_s2 [1:LM];
	logic [blaq_pkg::LEVEL_W-1:0] lvl_d, level_q;
	logic [blaq_pkg::CHAR_W-1:0]  char_q;

	assign adv2 = valid_s2 && (!out_valid_q || out_ready);
	assign adv1 = valid_s1 && (!valid_s2 || adv2);

	// operands: 9*sum without fraction bits, and k*255*count for each k
	assign nine_sum = {sum_s1, 3'b000} + (SW+4)'(sum_s1);
	assign xh_d     = nine_sum[SW+3:blaq_pkg::LUMA_FRAC];

	always_comb begin
		for (int k = 1; k <= LM; k++) begin
			thr_d[k] = XW'(XW'(cnt_s1) * XW'(k * blaq_pkg::PIX_MAX));
		end
	end

	// thresholds rise with k, so the last one met is the level
	always_comb begin
		lvl_d = '0;
		for (int k = 1; k <= LM; k++) begin
			if (xh_s2 >= thr_s2[k]) begin
				lvl_d = blaq_pkg::LEVEL_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			sum_s1  <= acc.sum;
			cnt_s1  <= acc.cnt;
			meta_s1 <= meta_in;
		end
		if (adv1) begin
			xh_s2   <= xh_d;
			thr_s2  <= thr_d;
			meta_s2 <= meta_s1;
		end
		if (adv2) begin
			level_q <= lvl_d;
			char_q  <= blaq_pkg::ramp_char(lvl_d);
			meta_q  <= meta_s2;
		end
	end

	assign full        = valid_s1;
	assign out_valid   = out_valid_q;
	assign ramp_level  = level_q;
	assign char_code   = char_q;
	assign zone_column = meta_q.col;
	assign zone_row    = meta_q.row;
	assign last_zone   = meta_q.last;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !valid_s1)
		else $error("zone result pushed into occupied stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv2 |=> valid_s2 && $stable(xh_s2))
		else $error("stalled compare stage lost its item");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> level_q <= blaq_pkg::LEVEL_W'(blaq_pkg::LEVEL_MAX))
		else $error("ramp level out of range");
`endif

endmodule

@@ sv/block_luma_ascii_quantizer.sv @@
// ----------------------------------------------------------------------------
// block_luma_ascii_quantizer
// Raster RGB pixels in, one brightness level and ramp character per zone out.
// ----------------------------------------------------------------------------
// The cycle a pixel is accepted reads its zone column's sum and count from
// a single RAM, the next cycle adds the pixel's luma and writes the entry
// back, and the input is held off during that write-back. A pixel that
// finishes a zone also holds the input while its result sits in the first
// quantizer stage, which it leaves once the next stage has room. A result
// passes the quantizer stages into the output register and waits there
// without blocking further pixels. There is no clearing pass after reset:
// a zone column's entry is overwritten at the zone's top-left pixel.
// Register writes are always taken and restart the image at its top-left
// pixel.
module block_luma_ascii_quantizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [blaq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blaq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [blaq_pkg::PIX_W-1:0]      red,
	input  logic [blaq_pkg::PIX_W-1:0]      green,
	input  logic [blaq_pkg::PIX_W-1:0]      blue,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [blaq_pkg::LEVEL_W-1:0]    ramp_level,
	output logic [blaq_pkg::CHAR_W-1:0]     char_code,
	output logic [blaq_pkg::ZONE_W-1:0]     zone_column,
	output logic [blaq_pkg::ZONE_W-1:0]     zone_row,
	output logic                            last_zone
);

	blaq_pkg::pixel_pos_t pos;
	blaq_pkg::acc_entry_t acc;
	blaq_pkg::zone_meta_t acc_meta;
	logic                 take, cfg_wr, acc_busy, acc_push, quant_full;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_ready  = !acc_busy && !quant_full;
	assign take      = in_valid && in_ready;

	blaq_raster u_raster (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (take),
		.pos      (pos)
	);

	blaq_accum u_accum (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.pos   (pos),
		.red   (red),
		.green (green),
		.blue  (blue),
		.busy  (acc_busy),
		.push  (acc_push),
		.acc   (acc),
		.meta  (acc_meta)
	);

	blaq_quant u_quant (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (acc_push),
		.acc        (acc),
		.meta_in    (acc_meta),
		.full       (quant_full),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ramp_level (ramp_level),
		.char_code  (char_code),
		.zone_column(zone_column),
		.zone_row   (zone_row),
		.last_zone  (last_zone)
	);

endmodule

@@ test/zone_level_checker.sv @@
// ----------------------------------------------------------------------------
// zone_level_checker
// Watches the register, pixel and result channels of the luma ASCII
// quantizer, predicts each zone's level, glyph and position, and compares.
// ----------------------------------------------------------------------------
module zone_level_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [blaq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blaq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [blaq_pkg::PIX_W-1:0]      red,
	input  logic [blaq_pkg::PIX_W-1:0]      green,
	input  logic [blaq_pkg::PIX_W-1:0]      blue,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [blaq_pkg::LEVEL_W-1:0]    ramp_level,
	input  logic [blaq_pkg::CHAR_W-1:0]     char_code,
	input  logic [blaq_pkg::ZONE_W-1:0]     zone_column,
	input  logic [blaq_pkg::ZONE_W-1:0]     zone_row,
	input  logic                            last_zone,
	output int                              mismatch_count,
	output int                              pending_zones,
	output int                              zones_checked
);

	localparam int unsigned LUMA_R = 19595;
	localparam int unsigned LUMA_G = 38470;
	localparam int unsigned LUMA_B = 7471;
	localparam longint unsigned FULL_SCALE = 255 * 65536;
	localparam int COLUMNS = 1024;

	typedef struct {
		logic [3:0] level;
		logic [6:0] glyph;
		logic [9:0] col;
		logic [9:0] row;
		logic       final_zone;
	} zone_result_t;

	zone_result_t expected_zones[$];

	// register copies, raw as written
	logic [10:0] img_w_reg;
	logic [10:0] img_h_reg;
	logic [6:0]  blk_w_reg;
	logic [6:0]  blk_h_reg;

	logic [35:0] luma_acc [COLUMNS];
	logic [12:0] count_acc [COLUMNS];
	logic [9:0]  col_pos;
	logic [9:0]  row_pos;
	logic [5:0]  ofs_x;
	logic [5:0]  ofs_y;
	logic [9:0]  zone_col;
	logic [9:0]  zone_row_pos;

	function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [6:0] glyph_for(input logic [3:0] level);
		case (level)
			4'd0:    return 7'd32;
			4'd1:    return 7'd46;
			4'd2:    return 7'd58;
			4'd3:    return 7'd45;
			4'd4:    return 7'd61;
			4'd5:    return 7'd43;
			4'd6:    return 7'd42;
			4'd7:    return 7'd35;
			4'd8:    return 7'd37;
			default: return 7'd64;
		endcase
	endfunction

	task automatic restart_image();
		col_pos = '0;
		row_pos = '0;
		ofs_x = '0;
		ofs_y = '0;
		zone_col = '0;
		zone_row_pos = '0;
	endtask

	task automatic clear_model();
		img_w_reg = 11'd640;
		img_h_reg = 11'd480;
		blk_w_reg = 7'd8;
		blk_h_reg = 7'd16;
		for (int i = 0; i < COLUMNS; i++) begin
			luma_acc[i] = '0;
			count_acc[i] = '0;
		end
		restart_image();
		expected_zones.delete();
		mismatch_count = 0;
		pending_zones = 0;
		zones_checked = 0;
	endtask

	task automatic apply_register(input logic [blaq_pkg::CFG_IDX_W-1:0] idx,
			input logic [10:0] data);
		case (idx)
			blaq_pkg::REG_IMAGE_WIDTH:  img_w_reg = data;
			blaq_pkg::REG_IMAGE_HEIGHT: img_h_reg = data;
			blaq_pkg::REG_BLOCK_WIDTH:  blk_w_reg = data[6:0];
			blaq_pkg::REG_BLOCK_HEIGHT: blk_h_reg = data[6:0];
			default: ;
		endcase
		// any write starts a fresh image; accumulators are left alone
		restart_image();
	endtask

	task automatic accumulate_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int unsigned eff_w;
		int unsigned eff_h;
		int unsigned eff_bw;
		int unsigned eff_bh;
		int unsigned luma;
		int unsigned zc;
		bit last_col;
		bit last_row;
		bit end_x;
		bit end_y;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] lvl;
		zone_result_t z;
		eff_w = clamp_reg(img_w_reg, blaq_pkg::MAX_IMAGE_WIDTH);
		eff_h = clamp_reg(img_h_reg, blaq_pkg::HEIGHT_LIMIT);
		eff_bw = clamp_reg(blk_w_reg, blaq_pkg::MAX_BLOCK_SIDE);
		eff_bh = clamp_reg(blk_h_reg, blaq_pkg::MAX_BLOCK_SIDE);
		luma = LUMA_R * r + LUMA_G * g + LUMA_B * b;
		zc = zone_col;
		if (ofs_x == 0 && ofs_y == 0) begin
			luma_acc[zc] = '0;
			count_acc[zc] = '0;
		end
		luma_acc[zc] = luma_acc[zc] + luma;
		count_acc[zc] = count_acc[zc] + 1'b1;
		last_col = (int'(col_pos) + 1 >= eff_w);
		last_row = (int'(row_pos) + 1 >= eff_h);
		end_x = (int'(ofs_x) + 1 >= eff_bw) || last_col;
		end_y = (int'(ofs_y) + 1 >= eff_bh) || last_row;
		if (end_x && end_y) begin
			num = 64'd9 * luma_acc[zc];
			den = FULL_SCALE * ((count_acc[zc] != 0) ? count_acc[zc] : 13'd1);
			lvl = num / den;
			if (lvl > 64'd9) lvl = 64'd9;
			z.level = lvl[3:0];
			z.glyph = glyph_for(lvl[3:0]);
			z.col = zone_col;
			z.row = zone_row_pos;
			z.final_zone = last_col && last_row;
			expected_zones.push_back(z);
		end
		if (last_col) begin
			col_pos = '0;
			ofs_x = '0;
			zone_col = '0;
			if (last_row) begin
				row_pos = '0;
				ofs_y = '0;
				zone_row_pos = '0;
			end else begin
				row_pos = row_pos + 1'b1;
				if (int'(ofs_y) + 1 >= eff_bh) begin
					ofs_y = '0;
					zone_row_pos = zone_row_pos + 1'b1;
				end else begin
					ofs_y = ofs_y + 1'b1;
				end
			end
		end else begin
			col_pos = col_pos + 1'b1;
			if (int'(ofs_x) + 1 >= eff_bw) begin
				ofs_x = '0;
				zone_col = zone_col + 1'b1;
			end else begin
				ofs_x = ofs_x + 1'b1;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d wanted %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_zone();
		zone_result_t want;
		if (expected_zones.size() == 0) begin
			report_mismatch("result with nothing pending, zone_column", zone_column, -1);
			return;
		end
		want = expected_zones.pop_front();
		zones_checked++;
		if (ramp_level !== want.level) report_mismatch("ramp_level", ramp_level, want.level);
		if (char_code !== want.glyph) report_mismatch("char_code", char_code, want.glyph);
		if (zone_column !== want.col) report_mismatch("zone_column", zone_column, want.col);
		if (zone_row !== want.row) report_mismatch("zone_row", zone_row, want.row);
		if (last_zone !== want.final_zone)
			report_mismatch("last_zone", last_zone, want.final_zone);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			// a result always trails its pixel, so retire before predicting
			if (out_valid && out_ready) check_zone();
			if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
			if (in_valid && in_ready) accumulate_pixel(red, green, blue);
			pending_zones = expected_zones.size();
		end
	end

endmodule

@@ test/block_luma_ascii_quantizer_tb.sv @@
// ----------------------------------------------------------------------------
// block_luma_ascii_quantizer_tb
// Drives pixels and register writes into the quantizer with random stalls on
// both sides; the checker beside the block predicts and compares every zone.
// ----------------------------------------------------------------------------
module block_luma_ascii_quantizer_tb;

	localparam int STALL_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 420;
	localparam int CALM_AFTER   = 340;
	localparam int SETTLE_TAIL  = 12;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [blaq_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [blaq_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [blaq_pkg::PIX_W-1:0]      red;
	logic [blaq_pkg::PIX_W-1:0]      green;
	logic [blaq_pkg::PIX_W-1:0]      blue;
	logic                            out_valid;
	logic                            out_ready;
	logic [blaq_pkg::LEVEL_W-1:0]    ramp_level;
	logic [blaq_pkg::CHAR_W-1:0]     char_code;
	logic [blaq_pkg::ZONE_W-1:0]     zone_column;
	logic [blaq_pkg::ZONE_W-1:0]     zone_row;
	logic                            last_zone;

	int mismatch_count;
	int pending_zones;
	int zones_checked;
	int pixels_sent;
	int settings_used;
	bit calm;
	bit hold_req;

	block_luma_ascii_quantizer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ramp_level  (ramp_level),
		.char_code   (char_code),
		.zone_column (zone_column),
		.zone_row    (zone_row),
		.last_zone   (last_zone)
	);

	zone_level_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ramp_level     (ramp_level),
		.char_code      (char_code),
		.zone_column    (zone_column),
		.zone_row       (zone_row),
		.last_zone      (last_zone),
		.mismatch_count (mismatch_count),
		.pending_zones  (pending_zones),
		.zones_checked  (zones_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// result side: random back-pressure, plus one long hold on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// leaves in_valid high; settle() lowers it
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pixels_sent++;
	endtask

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_pixel();
		logic [7:0] v;
		case ($urandom_range(0, 7))
			0: send_pixel(8'd0, 8'd0, 8'd0);
			1: send_pixel(8'd255, 8'd255, 8'd255);
			2: begin
				v = 8'($urandom_range(0, 255));
				send_pixel(v, v, v);
			end
			default: send_pixel(pick_channel(), pick_channel(), pick_channel());
		endcase
	endtask

	// leaves cfg_valid high so back-to-back writes need one assignment per edge
	task automatic write_reg(input blaq_pkg::cfg_reg_t idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[blaq_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_shape(input int w, input int h, input int bw, input int bh);
		write_reg(blaq_pkg::REG_IMAGE_WIDTH, w);
		write_reg(blaq_pkg::REG_IMAGE_HEIGHT, h);
		write_reg(blaq_pkg::REG_BLOCK_WIDTH, bw);
		write_reg(blaq_pkg::REG_BLOCK_HEIGHT, bh);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// wait out every pending zone plus the pipeline tail before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_zones != 0) @(posedge clk);
		repeat (SETTLE_TAIL) @(posedge clk);
	endtask

	initial begin
		int grays[11];
		int random_sent;
		int phase;
		int n;
		int w;
		int h;
		int cur_w;
		int cur_h;
		int area;
		int v;
		grays = '{0, 28, 29, 57, 85, 114, 142, 170, 199, 227, 255};
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		cfg_valid = 1'b0;
		cfg_index = blaq_pkg::REG_IMAGE_WIDTH;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		pixels_sent = 0;
		settings_used = 1;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// a few pixels on the reset shape, cut off by the first write
		repeat (4) send_random_pixel();
		settle();

		// one-pixel zones: every level boundary and pure red
		program_shape(4, 3, 1, 1);
		foreach (grays[i]) send_pixel(8'(grays[i]), 8'(grays[i]), 8'(grays[i]));
		send_pixel(8'd255, 8'd0, 8'd0);
		settle();

		// zero registers read as one: a one-wide, two-tall image of one-pixel zones, sent twice
		program_shape(0, 2, 0, 0);
		repeat (4) send_random_pixel();
		settle();

		// edge zones cut short on the right and bottom
		program_shape(3, 2, 2, 5);
		repeat (6) send_random_pixel();
		settle();

		// oversize values clamp: 64-wide zones, high data bits ignored
		program_shape(2047, 0, 'h7FF, 'h780);
		repeat (128) send_random_pixel();
		settle();

		// one-pixel-wide image, height over the limit, 64-tall zones
		program_shape(1, 1500, 1, 64);
		repeat (128) send_random_pixel();
		settle();

		random_sent = 0;
		phase = 0;
		cur_w = 1;
		cur_h = 1;
		while (random_sent < RANDOM_ITEMS) begin
			calm = (random_sent >= CALM_AFTER);
			if (phase == 0) begin
				// results every pixel while the receiver holds off: input must stall
				program_shape(8, 8, 1, 1);
				cur_w = 8;
				cur_h = 8;
				hold_req = 1'b1;
				n = 64;
			end else begin
				if ($urandom_range(0, 5) == 0) begin
					case ($urandom_range(0, 3))
						0: begin
							v = $urandom_range(1, 12);
							write_reg(blaq_pkg::REG_IMAGE_WIDTH, v);
							cur_w = v;
						end
						1: begin
							v = $urandom_range(1, 8);
							write_reg(blaq_pkg::REG_IMAGE_HEIGHT, v);
							cur_h = v;
						end
						2: write_reg(blaq_pkg::REG_BLOCK_WIDTH,
							$urandom_range(0, 9) | ($urandom_range(0, 15) << 7));
						default: write_reg(blaq_pkg::REG_BLOCK_HEIGHT,
							$urandom_range(0, 9) | ($urandom_range(0, 15) << 7));
					endcase
					cfg_valid <= 1'b0;
					settings_used++;
				end else begin
					w = $urandom_range(0, 12);
					h = $urandom_range(0, 8);
					program_shape(w, h,
						$urandom_range(0, w + 1) | ($urandom_range(0, 15) << 7),
						$urandom_range(0, h + 1) | ($urandom_range(0, 15) << 7));
					cur_w = (w == 0) ? 1 : w;
					cur_h = (h == 0) ? 1 : h;
				end
				area = cur_w * cur_h;
				// a partial image makes the next write restart mid-frame
				if ($urandom_range(0, 3) == 0)
					n = $urandom_range(1, area);
				else
					n = area * $urandom_range(1, 3);
			end
			// keep the total near the budget and start the calm tail on a phase edge
			if (n > RANDOM_ITEMS - random_sent)
				n = RANDOM_ITEMS - random_sent;
			if (random_sent < CALM_AFTER && random_sent + n > CALM_AFTER)
				n = CALM_AFTER - random_sent;
			repeat (n) send_random_pixel();
			random_sent += n;
			phase++;
			settle();
		end

		$display("Run covered %0d pixels over %0d register settings: level edges, clamping,",
			pixels_sent, settings_used);
		$display("cut-off zones, mid-image restarts and a long output hold; %0d zones compared",
			zones_checked);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
